// ===== rtl/dchop_pkg.sv =====
`default_nettype none

package dchop_pkg;

    localparam int unsigned TIMER_W = 5;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_WR_DRIVE   = 3'd1,
        CMD_WR_EN_MAIN = 3'd2,
        CMD_WR_EN_DUAL = 3'd3,
        CMD_RD_SENSE   = 3'd4
    } cmd_t;

    localparam logic [7:0]         ENABLE_KEY     = 8'h4D;
    localparam logic [TIMER_W-1:0] COIN_ON_TIME   = TIMER_W'(30);
    localparam logic [TIMER_W-1:0] COIN_GAP_TIME  = TIMER_W'(10);
    localparam logic [7:0]         SEL_MASK       = 8'h50;
    localparam logic [7:0]         SEL_SINGLE     = 8'h10;
    localparam logic [7:0]         SEL_DUAL       = 8'h00;
    localparam logic [7:0]         SENSE_DUAL_BIT = 8'h40;
    localparam logic [7:0]         SENSE_FIXED    = 8'h24;
    localparam logic [7:0]         OPTO_ONE_MASK  = 8'h09;
    localparam logic [7:0]         OPTO_TWO_MASK  = 8'h0A;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data;
    } in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       motor_one_on;
        logic       motor_two_on;
    } out_t;

    typedef struct packed {
        logic tick;
        logic eval;
        logic run;
    } hop_ctl_t;

    typedef struct packed {
        logic motor;
        logic motor_after;
        logic coin;
    } hop_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dchop_hopper.sv =====
`default_nettype none

module dchop_hopper (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dchop_pkg::hop_ctl_t  ctl,
    output dchop_pkg::hop_stat_t      stat
);

    logic                             motor_reg, motor_next;
    logic                             coin_reg, coin_next;
    logic                             phase_reg, phase_next;
    logic [dchop_pkg::TIMER_W-1:0]    timer_reg, timer_next;
    logic [dchop_pkg::TIMER_W-1:0]    timer_dec;

    assign timer_dec = timer_reg - dchop_pkg::TIMER_W'(1);

    always_comb
    begin
        motor_next = motor_reg;
        coin_next  = coin_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        if (ctl.eval)
        begin
            if (ctl.run)
            begin
                if (!motor_reg)
                begin
                    motor_next = 1'b1;
                    timer_next = dchop_pkg::COIN_ON_TIME;
                    coin_next  = 1'b0;
                end
            end
            else
            begin
                motor_next = 1'b0;
                timer_next = '0;
                coin_next  = 1'b0;
            end
        end
        else if (ctl.tick && (timer_reg != '0))
        begin
            if (timer_dec == '0)
            begin
                // toggle coin, reload for the next half period
                if (!phase_reg)
                begin
                    coin_next  = 1'b1;
                    timer_next = dchop_pkg::COIN_ON_TIME;
                    phase_next = 1'b1;
                end
                else
                begin
                    coin_next  = 1'b0;
                    timer_next = dchop_pkg::COIN_GAP_TIME;
                    phase_next = 1'b0;
                end
            end
            else
            begin
                timer_next = timer_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg <= 1'b0;
            coin_reg  <= 1'b0;
            phase_reg <= 1'b0;
            timer_reg <= '0;
        end
        else
        begin
            motor_reg <= motor_next;
            coin_reg  <= coin_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
        end
    end

    assign stat.motor       = motor_reg;
    assign stat.motor_after = motor_next;
    assign stat.coin        = coin_reg;

    a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !motor_reg |-> (timer_reg == '0) && !coin_reg)
        else $error("stopped hopper holds timer or coin");

    a_running_timer: assert property (@(posedge clk) disable iff (!rst_n)
        motor_reg |-> (timer_reg != '0) && (timer_reg <= dchop_pkg::COIN_ON_TIME))
        else $error("running hopper timer out of range");

    a_coin_toggle_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.tick && !ctl.eval && timer_reg == dchop_pkg::TIMER_W'(1))
            |=> (coin_reg == !$past(phase_reg)) && (phase_reg != $past(phase_reg))
                && (timer_reg != '0))
        else $error("expiry did not set coin from phase and reload");

endmodule

`default_nettype wire

// ===== rtl/dual_coin_hopper_model_top.sv =====
`default_nettype none

// Dual coin hopper model. Each accepted item (tick, drive/enable write or
// sense read) yields exactly one result item, registered at acceptance.
// One item is accepted every clock while the result register is empty or
// being drained (in_ready stays high while that holds); it is the only stage.
// Writes update the drive byte and enable flags and re-evaluate the optos and
// motors in the same cycle; ticks count the pulse timers of both hoppers.
// hopper_type is written through the cfg channel, which is always ready.

module dual_coin_hopper_model_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dchop_pkg::in_t    in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dchop_pkg::out_t        out_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);

    logic [7:0]           hopper_type_reg;
    logic [7:0]           drive_reg, drive_next;
    logic                 en_main_reg, en_main_next;
    logic                 en_dual_reg, en_dual_next;
    logic                 opto_one_reg, opto_one_next;
    logic                 opto_two_reg, opto_two_next;
    logic                 out_valid_reg;
    dchop_pkg::out_t      out_item_reg;
    dchop_pkg::out_t      result;
    logic                 in_accept;
    logic                 is_write;
    logic                 s1, s2;
    logic [7:0]           sense;
    logic [7:0]           sel;
    dchop_pkg::hop_ctl_t  ctl_one, ctl_two;
    dchop_pkg::hop_stat_t stat_one, stat_two;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign is_write = (in_item.cmd == dchop_pkg::CMD_WR_DRIVE)
                   || (in_item.cmd == dchop_pkg::CMD_WR_EN_MAIN)
                   || (in_item.cmd == dchop_pkg::CMD_WR_EN_DUAL);

    always_comb
    begin
        drive_next   = drive_reg;
        en_main_next = en_main_reg;
        en_dual_next = en_dual_reg;
        case (in_item.cmd)
            dchop_pkg::CMD_WR_DRIVE:   drive_next   = in_item.data;
            dchop_pkg::CMD_WR_EN_MAIN: en_main_next = (in_item.data == dchop_pkg::ENABLE_KEY);
            dchop_pkg::CMD_WR_EN_DUAL: en_dual_next = (in_item.data == dchop_pkg::ENABLE_KEY);
            default: ;
        endcase
    end

    assign opto_one_next = en_main_next
        && ((drive_next & dchop_pkg::OPTO_ONE_MASK) == dchop_pkg::OPTO_ONE_MASK);
    assign opto_two_next = en_main_next
        && ((drive_next & dchop_pkg::OPTO_TWO_MASK) == dchop_pkg::OPTO_TWO_MASK);

    assign ctl_one.tick = in_accept && (in_item.cmd == dchop_pkg::CMD_TICK);
    assign ctl_one.eval = in_accept && is_write;
    assign ctl_one.run  = en_main_next && drive_next[0] && en_dual_next;
    assign ctl_two.tick = ctl_one.tick;
    assign ctl_two.eval = ctl_one.eval;
    assign ctl_two.run  = en_main_next && drive_next[1] && en_dual_next;

    dchop_hopper u_hop_one (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_one),
        .stat  (stat_one)
    );

    dchop_hopper u_hop_two (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_two),
        .stat  (stat_two)
    );

    assign s1  = stat_one.coin ^ opto_one_reg;
    assign s2  = stat_two.coin ^ opto_two_reg;
    assign sel = hopper_type_reg & dchop_pkg::SEL_MASK;

    always_comb
    begin
        case (sel)
            dchop_pkg::SEL_SINGLE: sense = {7'b0, s1};
            dchop_pkg::SEL_DUAL:   sense = {6'b0, s2 ^ en_dual_reg, s1 ^ en_dual_reg};
            default:               sense = {6'b0, s1, s2};
        endcase
        if (en_dual_reg)
        begin
            sense = sense | dchop_pkg::SENSE_DUAL_BIT;
        end
        sense = sense | dchop_pkg::SENSE_FIXED;
    end

    assign result.read_data    = (in_item.cmd == dchop_pkg::CMD_RD_SENSE) ? sense : 8'h00;
    assign result.motor_one_on = stat_one.motor_after;
    assign result.motor_two_on = stat_two.motor_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hopper_type_reg <= '0;
            drive_reg       <= '0;
            en_main_reg     <= 1'b0;
            en_dual_reg     <= 1'b0;
            opto_one_reg    <= 1'b0;
            opto_two_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                hopper_type_reg <= cfg_data;
            end
            if (in_accept && is_write)
            begin
                drive_reg    <= drive_next;
                en_main_reg  <= en_main_next;
                en_dual_reg  <= en_dual_next;
                opto_one_reg <= opto_one_next;
                opto_two_reg <= opto_two_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_read_fixed_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_item.cmd == dchop_pkg::CMD_RD_SENSE)
            |=> out_item.read_data[5] && out_item.read_data[2])
        else $error("sense item missing fixed bits");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_item.cmd != dchop_pkg::CMD_RD_SENSE)
            |=> out_item.read_data == 8'h00)
        else $error("non-read item carries read data");

    a_motor_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_one.motor || stat_two.motor) |-> en_main_reg && en_dual_reg)
        else $error("motor running without both enables");

endmodule

`default_nettype wire
